// ===== hdl/at_response_end_detector_macros.svh =====
// assertion macros for the at response end detector checker
`ifndef AT_RESPONSE_END_DETECTOR_MACROS_SVH
`define AT_RESPONSE_END_DETECTOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ATRED_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atred check failed");

// antecedent implies consequent in the next cycle
`define ATRED_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atred check failed");

`endif

// ===== hdl/atred_pkg.sv =====
// shared types, codes and constants of the at response end detector
`default_nettype none

package atred_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int TAG_COUNT   = 4;
    localparam int TAG_MAX_LEN = 8;
    localparam int EOL_MAX_LEN = 4;
    localparam int RECENT_LEN  = EOL_MAX_LEN + TAG_MAX_LEN;

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int COUNT_W = $clog2(STORE_DEPTH + 1);
    localparam int LEN_W   = COUNT_W + 2;
    localparam int EL_W    = 3;
    localparam int TL_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [31:0] EOL_CHARS_RESET = 32'd3338;
    localparam logic [2:0]  EOL_LENGTH_RESET = 3'd2;
    localparam logic [31:0] TIMEOUT_RESET   = 32'd1000;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_DONE = 2'd2,
        CMD_READ = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EOL_CHARS   = 3'd0,
        CFG_EOL_LENGTH  = 3'd1,
        CFG_TAG_LENGTHS = 3'd2,
        CFG_TAG_ZERO    = 3'd3,
        CFG_TAG_ONE     = 3'd4,
        CFG_TAG_TWO     = 3'd5,
        CFG_TAG_THREE   = 3'd6,
        CFG_TIMEOUT     = 3'd7
    } cfg_idx_t;

    // phase codes as seen on the output word
    localparam logic [1:0] PHASE_IDLE     = 2'd0;
    localparam logic [1:0] PHASE_RECV     = 2'd1;
    localparam logic [1:0] PHASE_COMPLETE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'b001,
        ST_RECV     = 3'b010,
        ST_COMPLETE = 3'b100
    } rx_state_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data_byte;
        logic [7:0] read_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         phase;
        logic               line_ended;
        logic               tag_found;
        logic [1:0]         tag_number;
        logic               timed_out;
        logic               overflow;
        logic [COUNT_W-1:0] stored_count;
        logic [7:0]         read_data;
    } out_word_t;

    typedef struct packed {
        logic [31:0]                 eol_chars;
        logic [EL_W-1:0]             eol_length;
        logic [15:0]                 tag_lengths;
        logic [TAG_COUNT-1:0][63:0]  tag_bytes;
        logic [31:0]                 timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } store_req_t;

endpackage

`default_nettype wire

// ===== hdl/at_response_end_detector.sv =====
// top level of the at response end detector
// Takes one word per cycle (byte, tick, done or read command) while in_ready
// is high, giving one result word per word via the stage-one and output
// registers. Each byte not refused as overflow goes into a 256-entry
// synchronous store at the running count while the newest twelve bytes are
// compared in the same cycle with the end-of-line string and the four end
// tags; reads go through the store's registered port. Sustained rate is one
// word per cycle with out_ready held high. No clearing pass runs after reset
// or done: a read at or above the stored count returns zero whatever the
// store holds. The user must write configuration through cfg_we, cfg_index
// and cfg_wdata while no word is in flight; the block does not enforce it.
`default_nettype none

module at_response_end_detector (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  atred_pkg::in_word_t                    in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output atred_pkg::out_word_t                   out_data,
    input  wire logic                              cfg_we,
    input  wire logic [atred_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [atred_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    atred_pkg::cfg_t       cfg;
    atred_pkg::out_word_t  scan_res;
    atred_pkg::store_req_t req;
    logic                  scan_hit;
    logic [7:0]            store_q;
    logic                  in_fire;
    logic                  s1_move;

    // stage one: result of the scan, store read data arriving alongside
    logic                  s1_valid_reg;
    atred_pkg::out_word_t  s1_res_reg;
    logic                  s1_hit_reg;

    // output register
    logic                  out_valid_reg;
    atred_pkg::out_word_t  out_data_reg;
    atred_pkg::out_word_t  out_data_next;

    // stage one drains when the output register is free or being emptied
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_fire  = in_valid && in_ready;

    atred_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    atred_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (in_fire),
        .in_word (in_data),
        .cfg     (cfg),
        .res     (scan_res),
        .rd_hit  (scan_hit),
        .req     (req)
    );

    // store read data holds until the next read, which only comes with a new word
    atred_store u_store (
        .clk (clk),
        .req (req),
        .q   (store_q)
    );

    always_comb
    begin
        out_data_next           = s1_res_reg;
        out_data_next.read_data = s1_hit_reg ? store_q : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_res_reg <= scan_res;
            s1_hit_reg <= scan_hit;
        end
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== hdl/atred_cfg_regs.sv =====
// configuration register bank of the at response end detector
`default_nettype none

module atred_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [atred_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [atred_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output atred_pkg::cfg_t                       cfg
);

    atred_pkg::cfg_t cfg_reg;
    atred_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (atred_pkg::cfg_idx_t'(cfg_index))
                atred_pkg::CFG_EOL_CHARS:   cfg_next.eol_chars     = cfg_wdata[31:0];
                atred_pkg::CFG_EOL_LENGTH:  cfg_next.eol_length    = cfg_wdata[2:0];
                atred_pkg::CFG_TAG_LENGTHS: cfg_next.tag_lengths   = cfg_wdata[15:0];
                atred_pkg::CFG_TIMEOUT:     cfg_next.timeout_ticks = cfg_wdata[31:0];
                default:
                begin
                end
            endcase
            // tag byte registers sit at consecutive indexes
            for (int t = 0; t < atred_pkg::TAG_COUNT; t++)
            begin
                if (cfg_index == atred_pkg::CFG_TAG_ZERO + atred_pkg::CFG_IDX_W'(t))
                begin
                    cfg_next.tag_bytes[t] = cfg_wdata[63:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eol_chars     <= atred_pkg::EOL_CHARS_RESET;
            cfg_reg.eol_length    <= atred_pkg::EOL_LENGTH_RESET;
            cfg_reg.tag_lengths   <= '0;
            cfg_reg.tag_bytes     <= '0;
            cfg_reg.timeout_ticks <= atred_pkg::TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/atred_store.sv =====
// response byte store, one write port and one read port, registered read
`default_nettype none

module atred_store (
    input  wire logic              clk,
    input  atred_pkg::store_req_t  req,
    output logic [7:0]             q
);

    logic [7:0] mem [atred_pkg::STORE_DEPTH];
    logic [7:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            q_reg <= mem[req.raddr];
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// ===== hdl/atred_scan.sv =====
// reception state, end-of-line and end-tag matching, store addressing
`default_nettype none

module atred_scan (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  atred_pkg::in_word_t    in_word,
    input  atred_pkg::cfg_t        cfg,
    output atred_pkg::out_word_t   res,
    output logic                   rd_hit,
    output atred_pkg::store_req_t  req
);

    localparam int CW = atred_pkg::COUNT_W;
    localparam int LW = atred_pkg::LEN_W;
    localparam int RL = atred_pkg::RECENT_LEN;
    localparam int TC = atred_pkg::TAG_COUNT;
    localparam int TM = atred_pkg::TAG_MAX_LEN;
    localparam int EM = atred_pkg::EOL_MAX_LEN;

    atred_pkg::rx_state_t state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        start_reg, start_next;
    logic [RL-1:0][7:0]   recent_reg, recent_next;
    logic [31:0]          elapsed_reg, elapsed_next;
    logic                 tout_reg, tout_next;
    logic                 ovf_reg, ovf_next;

    logic [atred_pkg::EL_W-1:0] el;
    logic [RL-1:0][7:0]         recent_sh;
    logic [TM-1:0][7:0]         tail;
    logic [CW-1:0]              count_inc;
    logic                       eol_hit;
    logic signed [LW-1:0]       line_len;
    logic [TC-1:0]              tag_ok;
    logic [atred_pkg::TL_W-1:0] tl;
    logic [1:0]                 tnum;
    logic                       found;
    logic                       full;
    logic [31:0]                elapsed_inc;

    function automatic logic EL_LT(input int k, input logic [atred_pkg::EL_W-1:0] n);
        EL_LT = (atred_pkg::EL_W'(k) < n);
    endfunction

    // effective end-of-line length, clamped to 1..EOL_MAX_LEN
    always_comb
    begin
        if (cfg.eol_length == '0)
            el = atred_pkg::EL_W'(1);
        else if (cfg.eol_length > atred_pkg::EL_W'(EM))
            el = atred_pkg::EL_W'(EM);
        else
            el = cfg.eol_length;
    end

    assign recent_sh = {recent_reg[RL-2:0], in_word.data_byte};
    assign count_inc = count_reg + CW'(1);
    assign full      = (count_reg >= CW'(atred_pkg::STORE_DEPTH));

    // end-of-line compare on the newest bytes
    always_comb
    begin
        eol_hit = (count_inc >= CW'(el));
        for (int k = 0; k < EM; k++)
        begin
            if (EL_LT(k, el) && recent_sh[k] != cfg.eol_chars[8*k +: 8])
                eol_hit = 1'b0;
        end
    end

    // bytes just before the end-of-line string
    always_comb
    begin
        tail = '0;
        for (int k = 0; k < TM; k++)
        begin
            for (int e = 1; e <= EM; e++)
            begin
                if (el == atred_pkg::EL_W'(e))
                    tail[k] = recent_sh[e + k];
            end
        end
    end

    assign line_len = $signed(LW'(count_inc)) - $signed(LW'(el)) - $signed(LW'(start_reg));

    always_comb
    begin
        tag_ok = '0;
        tl     = '0;
        for (int t = 0; t < TC; t++)
        begin
            tl = cfg.tag_lengths[4*t +: 4];
            if (tl > atred_pkg::TL_W'(TM))
                tl = atred_pkg::TL_W'(TM);
            tag_ok[t] = (tl != '0) && ($signed(LW'(tl)) < line_len);
            for (int k = 0; k < TM; k++)
            begin
                if (atred_pkg::TL_W'(k) < tl && tail[k] != cfg.tag_bytes[t][8*k +: 8])
                    tag_ok[t] = 1'b0;
            end
        end
    end

    // first tag in list order wins
    always_comb
    begin
        tnum = '0;
        for (int t = TC - 1; t >= 0; t--)
        begin
            if (tag_ok[t])
                tnum = 2'(t);
        end
    end

    assign found       = |tag_ok;
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 32'd1;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        start_next   = start_reg;
        recent_next  = recent_reg;
        elapsed_next = elapsed_reg;
        tout_next    = tout_reg;
        ovf_next     = ovf_reg;
        req          = '0;
        rd_hit       = 1'b0;
        res          = '0;

        case (in_word.cmd)
            atred_pkg::CMD_BYTE:
            begin
                if (state_reg == atred_pkg::ST_IDLE)
                begin
                    state_next   = atred_pkg::ST_RECV;
                    elapsed_next = '0;
                end
                if (state_reg == atred_pkg::ST_COMPLETE || full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    req.we      = 1'b1;
                    req.waddr   = count_reg[atred_pkg::ADDR_W-1:0];
                    req.wdata   = in_word.data_byte;
                    count_next  = count_inc;
                    recent_next = recent_sh;
                    if (eol_hit)
                    begin
                        res.line_ended = 1'b1;
                        res.tag_found  = found;
                        res.tag_number = found ? tnum : 2'd0;
                        start_next     = count_inc;
                        if (found)
                            state_next = atred_pkg::ST_COMPLETE;
                    end
                end
            end
            atred_pkg::CMD_TICK:
            begin
                if (state_reg == atred_pkg::ST_RECV)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > cfg.timeout_ticks)
                    begin
                        state_next = atred_pkg::ST_COMPLETE;
                        tout_next  = 1'b1;
                    end
                end
            end
            atred_pkg::CMD_DONE:
            begin
                state_next   = atred_pkg::ST_IDLE;
                count_next   = '0;
                start_next   = '0;
                recent_next  = '0;
                elapsed_next = '0;
                tout_next    = 1'b0;
                ovf_next     = 1'b0;
            end
            atred_pkg::CMD_READ:
            begin
                req.re    = 1'b1;
                req.raddr = atred_pkg::ADDR_W'(in_word.read_index);
                rd_hit    = (32'(in_word.read_index) < 32'(count_reg));
            end
            default:
            begin
            end
        endcase

        case (state_next)
            atred_pkg::ST_RECV:     res.phase = atred_pkg::PHASE_RECV;
            atred_pkg::ST_COMPLETE: res.phase = atred_pkg::PHASE_COMPLETE;
            default:                res.phase = atred_pkg::PHASE_IDLE;
        endcase
        res.timed_out    = tout_next;
        res.overflow     = ovf_next;
        res.stored_count = count_next;

        // nothing moves unless the word is taken
        if (!fire)
            req = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= atred_pkg::ST_IDLE;
            count_reg   <= '0;
            start_reg   <= '0;
            recent_reg  <= '0;
            elapsed_reg <= '0;
            tout_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else if (fire)
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            start_reg   <= start_next;
            recent_reg  <= recent_next;
            elapsed_reg <= elapsed_next;
            tout_reg    <= tout_next;
            ovf_reg     <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/atred_checker.sv =====
// port-level assertions for the at response end detector, bound to the top level
`default_nettype none

`include "at_response_end_detector_macros.svh"

module atred_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  atred_pkg::out_word_t   out_data
);

    logic out_stall;
    logic no_tag;
    logic is_complete;
    logic tag_done;
    logic count_ok;

    assign out_stall   = out_valid && !out_ready;
    assign no_tag      = !out_data.tag_found;
    assign is_complete = (out_data.phase == atred_pkg::PHASE_COMPLETE);
    assign tag_done    = out_data.line_ended && is_complete;
    assign count_ok    = (out_data.stored_count <= atred_pkg::COUNT_W'(atred_pkg::STORE_DEPTH));

    // a stalled result word holds its value
    `ATRED_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data))

    // a found tag always comes with a line end and completes the response
    `ATRED_ASSERT_IMP(a_tag_completes, out_valid && out_data.tag_found, tag_done)

    // tag number reads zero without a tag
    `ATRED_ASSERT_IMP(a_tag_num_zero, out_valid && no_tag, out_data.tag_number == 2'd0)

    // a timeout leaves the response complete until cleared
    `ATRED_ASSERT_IMP(a_timeout_phase, out_valid && out_data.timed_out, is_complete)

    // the store never reports more bytes than it holds
    `ATRED_ASSERT_IMP(a_count_range, out_valid, count_ok)

endmodule

bind at_response_end_detector atred_checker u_checker (.*);

`default_nettype wire
